// ===== design/eyxz_pkg.sv =====
// Shared constants, types and functions of the Euler YXZ transform matrix core.
package eyxz_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int ATAN_W = 5;
   localparam int QUO_W = 25;
   localparam int REM_W = 16;
   localparam int DIV_PER_CELL = (QUO_W + CORDIC_STEPS - 1) / CORDIC_STEPS;
   localparam int DIV_TOTAL = CORDIC_STEPS * DIV_PER_CELL;
   localparam int DIV_ONE_POS = DIV_TOTAL - 1 - 24;
   localparam int PIPE_LEN = CORDIC_STEPS + 5;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [16:0] HALF_PI = 17'sd16384;
   localparam logic signed [16:0] FULL_PI = 17'sd32768;
   localparam logic signed [31:0] Q16_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q16_MIN = 32'sh80000000;

   localparam logic [1:0] KIND_MODEL = 2'd0;
   localparam logic [1:0] KIND_NORMAL = 2'd1;
   localparam logic [1:0] KIND_PLANAR = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]              kind;
      logic [2:0][31:0]        pos;
      logic [2:0][15:0]        scale;
      logic [2:0]              neg;
      logic [2:0][31:0]        x;
      logic [2:0][31:0]        y;
      logic [2:0][31:0]        z;
      logic [2:0][REM_W-1:0]   rem;
      logic [2:0][QUO_W-1:0]   quo;
      logic [2:0][15:0]        dvs;
   } pipe_type;

   function automatic logic signed [31:0] atan_angle(input logic [ATAN_W-1:0] idx);
      logic signed [31:0] a;
      unique case (idx)
         5'd0:  a = 32'sd536870912;
         5'd1:  a = 32'sd316933406;
         5'd2:  a = 32'sd167458907;
         5'd3:  a = 32'sd85004756;
         5'd4:  a = 32'sd42667331;
         5'd5:  a = 32'sd21354465;
         5'd6:  a = 32'sd10679838;
         5'd7:  a = 32'sd5340245;
         5'd8:  a = 32'sd2670163;
         5'd9:  a = 32'sd1335087;
         5'd10: a = 32'sd667544;
         5'd11: a = 32'sd333772;
         5'd12: a = 32'sd166886;
         5'd13: a = 32'sd83443;
         5'd14: a = 32'sd41722;
         5'd15: a = 32'sd20861;
         5'd16: a = 32'sd10430;
         5'd17: a = 32'sd5215;
         5'd18: a = 32'sd2608;
         5'd19: a = 32'sd1304;
         5'd20: a = 32'sd652;
         5'd21: a = 32'sd326;
         5'd22: a = 32'sd163;
         5'd23: a = 32'sd81;
         5'd24: a = 32'sd41;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd536870912;
      return p[61:30];
   endfunction

endpackage

// ===== design/eyxz_cell.sv =====
// One cell of the chain: a CORDIC rotation for three angles and reciprocal division steps.
module eyxz_cell (
   input  logic                        clock,
   input  logic                        en,
   input  logic [eyxz_pkg::STEP_W-1:0] step,
   input  eyxz_pkg::pipe_type          pipe_i,
   output eyxz_pkg::pipe_type          pipe_o
);

   eyxz_pkg::pipe_type pipe_in;
   eyxz_pkg::pipe_type pipe_ff;

   always_comb begin
      logic signed [31:0] xs, ys, zs, dx, dy, at;
      logic [eyxz_pkg::REM_W:0] sh;
      logic [eyxz_pkg::REM_W-1:0] r;
      logic [eyxz_pkg::QUO_W-1:0] q;
      logic b;
      pipe_in = pipe_i;
      at = eyxz_pkg::atan_angle(eyxz_pkg::ATAN_W'(step));
      for (int l = 0; l < 3; l++) begin
         xs = $signed(pipe_i.x[l]);
         ys = $signed(pipe_i.y[l]);
         zs = $signed(pipe_i.z[l]);
         dx = ys >>> step;
         dy = xs >>> step;
         if (!zs[31]) begin
            pipe_in.x[l] = xs - dx;
            pipe_in.y[l] = ys + dy;
            pipe_in.z[l] = zs - at;
         end else begin
            pipe_in.x[l] = xs + dx;
            pipe_in.y[l] = ys - dy;
            pipe_in.z[l] = zs + at;
         end
         r = pipe_i.rem[l];
         q = pipe_i.quo[l];
         for (int k = 0; k < eyxz_pkg::DIV_PER_CELL; k++) begin
            b = ((int'(step) * eyxz_pkg::DIV_PER_CELL + k) == eyxz_pkg::DIV_ONE_POS);
            sh = {r, b};
            if (sh >= {1'b0, pipe_i.dvs[l]}) begin
               sh = sh - {1'b0, pipe_i.dvs[l]};
               q = {q[eyxz_pkg::QUO_W-2:0], 1'b1};
            end else begin
               q = {q[eyxz_pkg::QUO_W-2:0], 1'b0};
            end
            r = sh[eyxz_pkg::REM_W-1:0];
         end
         pipe_in.rem[l] = r;
         pipe_in.quo[l] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign pipe_o = pipe_ff;

endmodule

// ===== design/eyxz_matrix.sv =====
// Products, column multipliers, rounding and saturation of the matrix entries.
module eyxz_matrix (
   input  logic                 clock,
   input  logic                 en,
   input  eyxz_pkg::pipe_type   pipe_i,
   output logic [11:0][31:0]    res
);

   logic [1:0]         kind1_ff, kind2_ff;
   logic [2:0][31:0]   pos1_ff, pos2_ff;
   logic [2:0][31:0]   m1_ff, m2_ff;
   logic [9:0][31:0]   pr1_ff;
   logic [31:0]        s2_ff, s3_ff, c3_ff;
   logic [8:0][32:0]   e2_ff;
   logic [8:0][64:0]   prod3_ff;
   logic [2:0][31:0]   tr3_ff;
   logic [11:0][31:0]  res_ff;

   logic [2:0][31:0]   sn, cs, m_in;
   logic [9:0][31:0]   pr_in;
   logic [8:0][32:0]   e_in;
   logic [8:0][64:0]   prod_in;
   logic [11:0][31:0]  res_in;

   always_comb begin
      logic signed [15:0] sc;
      logic signed [31:0] q32;
      logic signed [31:0] s1, c1, s2, c2, s3, c3;
      for (int l = 0; l < 3; l++) begin
         sn[l] = pipe_i.neg[l] ? -pipe_i.y[l] : pipe_i.y[l];
         cs[l] = pipe_i.neg[l] ? -pipe_i.x[l] : pipe_i.x[l];
      end
      s2 = $signed(sn[0]);
      c2 = $signed(cs[0]);
      s1 = $signed(sn[1]);
      c1 = $signed(cs[1]);
      s3 = $signed(sn[2]);
      c3 = $signed(cs[2]);
      pr_in[0] = eyxz_pkg::mul30(s1, s2);
      pr_in[1] = eyxz_pkg::mul30(c1, s2);
      pr_in[2] = eyxz_pkg::mul30(c1, c3);
      pr_in[3] = eyxz_pkg::mul30(c2, s3);
      pr_in[4] = eyxz_pkg::mul30(c3, s1);
      pr_in[5] = eyxz_pkg::mul30(c1, s3);
      pr_in[6] = eyxz_pkg::mul30(c2, c3);
      pr_in[7] = eyxz_pkg::mul30(s1, s3);
      pr_in[8] = eyxz_pkg::mul30(c2, s1);
      pr_in[9] = eyxz_pkg::mul30(c1, c2);
      for (int j = 0; j < 3; j++) begin
         sc = $signed(pipe_i.scale[j]);
         q32 = $signed({7'b0, pipe_i.quo[j]});
         unique case (pipe_i.kind)
            eyxz_pkg::KIND_MODEL, eyxz_pkg::KIND_PLANAR: begin
               m_in[j] = {{8{sc[15]}}, sc, 8'b0};
            end
            eyxz_pkg::KIND_NORMAL: begin
               if (sc == 16'sd0) begin
                  m_in[j] = eyxz_pkg::Q16_MAX;
               end else begin
                  m_in[j] = sc[15] ? -q32 : q32;
               end
            end
            default: begin
               m_in[j] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff <= pipe_i.kind;
         pos1_ff <= pipe_i.pos;
         m1_ff <= m_in;
         pr1_ff <= pr_in;
         s2_ff <= sn[0];
         s3_ff <= sn[2];
         c3_ff <= cs[2];
      end
   end

   always_comb begin
      logic signed [31:0] s3, c3;
      s3 = $signed(s3_ff);
      c3 = $signed(c3_ff);
      e_in = '0;
      unique case (kind1_ff)
         eyxz_pkg::KIND_MODEL, eyxz_pkg::KIND_NORMAL: begin
            e_in[0] = 33'($signed(pr1_ff[2]))
                    + 33'(eyxz_pkg::mul30($signed(pr1_ff[0]), s3));
            e_in[1] = 33'($signed(pr1_ff[3]));
            e_in[2] = 33'(eyxz_pkg::mul30($signed(pr1_ff[1]), s3))
                    - 33'($signed(pr1_ff[4]));
            e_in[3] = 33'(eyxz_pkg::mul30($signed(pr1_ff[0]), c3))
                    - 33'($signed(pr1_ff[5]));
            e_in[4] = 33'($signed(pr1_ff[6]));
            e_in[5] = 33'(eyxz_pkg::mul30($signed(pr1_ff[1]), c3))
                    + 33'($signed(pr1_ff[7]));
            e_in[6] = 33'($signed(pr1_ff[8]));
            e_in[7] = -33'($signed(s2_ff));
            e_in[8] = 33'($signed(pr1_ff[9]));
         end
         eyxz_pkg::KIND_PLANAR: begin
            e_in[0] = 33'(c3);
            e_in[1] = 33'(s3);
            e_in[3] = -33'(s3);
            e_in[4] = 33'(c3);
         end
         default: begin
            e_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind2_ff <= kind1_ff;
         pos2_ff <= pos1_ff;
         m2_ff <= m1_ff;
         e2_ff <= e_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 9; j++) begin
         prod_in[j] = $signed(e2_ff[j]) * $signed(m2_ff[j / 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod3_ff <= prod_in;
         tr3_ff <= (kind2_ff == eyxz_pkg::KIND_MODEL) ? pos2_ff : '0;
      end
   end

   always_comb begin
      logic signed [64:0] rnd;
      logic signed [34:0] sh;
      for (int j = 0; j < 9; j++) begin
         rnd = $signed(prod3_ff[j]) + 65'sd536870912;
         sh = rnd[64:30];
         if (sh > 35'(eyxz_pkg::Q16_MAX)) begin
            res_in[j] = eyxz_pkg::Q16_MAX;
         end else if (sh < 35'(eyxz_pkg::Q16_MIN)) begin
            res_in[j] = eyxz_pkg::Q16_MIN;
         end else begin
            res_in[j] = sh[31:0];
         end
      end
      for (int j = 0; j < 3; j++) begin
         res_in[9 + j] = tr3_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== design/euler_yxz_transform_matrix_core.sv =====
// Top level of the Euler YXZ transform matrix core: input stage, cell chain and matrix stages.
// The core takes one transfer per cycle while req_ready is high. Each item passes through
// an input register, one chain cell per CORDIC step (each cell also works out part of
// the three scale reciprocals), and four stages of products, column scaling, rounding
// and saturation. All stages move together, so when a result waits untaken the whole
// pipeline holds and req_ready is low; otherwise a new item may enter in every cycle.
// There is no configuration and no state between items.
module euler_yxz_transform_matrix_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [15:0] req_rot_x,
   input  logic [15:0] req_rot_y,
   input  logic [15:0] req_rot_z,
   input  logic [15:0] req_scale_x,
   input  logic [15:0] req_scale_y,
   input  logic [15:0] req_scale_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_col0_row0,
   output logic [31:0] rsp_col0_row1,
   output logic [31:0] rsp_col0_row2,
   output logic [31:0] rsp_col1_row0,
   output logic [31:0] rsp_col1_row1,
   output logic [31:0] rsp_col1_row2,
   output logic [31:0] rsp_col2_row0,
   output logic [31:0] rsp_col2_row1,
   output logic [31:0] rsp_col2_row2,
   output logic [31:0] rsp_trans_x,
   output logic [31:0] rsp_trans_y,
   output logic [31:0] rsp_trans_z
);

   logic en;
   logic [eyxz_pkg::PIPE_LEN-1:0] vld_ff, vld_in;
   eyxz_pkg::pipe_type prep_in, prep_ff;
   eyxz_pkg::pipe_type chain [eyxz_pkg::CORDIC_STEPS:0];
   logic [11:0][31:0] res;

   assign en = !vld_ff[eyxz_pkg::PIPE_LEN-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[eyxz_pkg::PIPE_LEN-1];

   assign vld_in = {vld_ff[eyxz_pkg::PIPE_LEN-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      logic [2:0][15:0] ang;
      logic signed [16:0] a;
      logic [16:0] mag;
      ang = {req_rot_z, req_rot_y, req_rot_x};
      prep_in.kind = req_kind;
      prep_in.pos = {req_pos_z, req_pos_y, req_pos_x};
      prep_in.scale = {req_scale_z, req_scale_y, req_scale_x};
      for (int l = 0; l < 3; l++) begin
         a = 17'($signed(ang[l]));
         prep_in.neg[l] = 1'b0;
         if (a > eyxz_pkg::HALF_PI) begin
            a = a - eyxz_pkg::FULL_PI;
            prep_in.neg[l] = 1'b1;
         end else if (a < -eyxz_pkg::HALF_PI) begin
            a = a + eyxz_pkg::FULL_PI;
            prep_in.neg[l] = 1'b1;
         end
         prep_in.x[l] = eyxz_pkg::CORDIC_GAIN;
         prep_in.y[l] = '0;
         prep_in.z[l] = {a[15:0], 16'b0};
         prep_in.rem[l] = '0;
         prep_in.quo[l] = '0;
         mag = prep_in.scale[l][15] ? -17'($signed(prep_in.scale[l]))
                                    : 17'($signed(prep_in.scale[l]));
         prep_in.dvs[l] = mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign chain[0] = prep_ff;

   for (genvar i = 0; i < eyxz_pkg::CORDIC_STEPS; i++) begin : g_cell
      eyxz_cell u_cell (
         .clock  (clock),
         .en     (en),
         .step   (eyxz_pkg::STEP_W'(i)),
         .pipe_i (chain[i]),
         .pipe_o (chain[i + 1])
      );
   end

   eyxz_matrix u_matrix (
      .clock  (clock),
      .en     (en),
      .pipe_i (chain[eyxz_pkg::CORDIC_STEPS]),
      .res    (res)
   );

   assign rsp_col0_row0 = res[0];
   assign rsp_col0_row1 = res[1];
   assign rsp_col0_row2 = res[2];
   assign rsp_col1_row0 = res[3];
   assign rsp_col1_row1 = res[4];
   assign rsp_col1_row2 = res[5];
   assign rsp_col2_row0 = res[6];
   assign rsp_col2_row1 = res[7];
   assign rsp_col2_row2 = res[8];
   assign rsp_trans_x = res[9];
   assign rsp_trans_y = res[10];
   assign rsp_trans_z = res[11];

endmodule

// ===== test/tb_euler_yxz_transform_matrix_core.sv =====
// Testbench for the Euler YXZ transform matrix core: random and directed items against a predictor.
`timescale 1ns / 1ps
module tb_euler_yxz_transform_matrix_core;

   typedef struct {
      logic [1:0] kind;
      logic [31:0] pos [3];
      logic [15:0] rot [3];
      logic [15:0] scale [3];
   } pose_type;

   typedef struct {
      logic [31:0] v [12];
   } matrix_type;

   localparam int LATENCY = eyxz_pkg::CORDIC_STEPS + 5;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = eyxz_pkg::KIND_MODEL;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [15:0] req_rot_x = '0, req_rot_y = '0, req_rot_z = '0;
   logic [15:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_col0_row0, rsp_col0_row1, rsp_col0_row2;
   logic [31:0] rsp_col1_row0, rsp_col1_row1, rsp_col1_row2;
   logic [31:0] rsp_col2_row0, rsp_col2_row1, rsp_col2_row2;
   logic [31:0] rsp_trans_x, rsp_trans_y, rsp_trans_z;

   int send_idle = 14;
   int recv_idle = 67;
   int cycle_count = 0;
   int kind_seen [4];

   euler_yxz_transform_matrix_core i_dut (.*);

   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic void sine_cosine(logic [15:0] angle, output longint sn, output longint cs);
      longint x, y, z, t, dx, dy;
      int a;
      bit flip;
      a = $signed(angle);
      flip = 1'b0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      x = 652032874;
      y = 0;
      z = longint'(a) * 65536;
      for (int i = 0; i < eyxz_pkg::CORDIC_STEPS && i < 25; i++) begin
         dx = shift_down(y, i);
         dy = shift_down(x, i);
         if (z >= 0) begin
            t = x - dx;
            y = y + dy;
            z -= longint'(eyxz_pkg::atan_angle(eyxz_pkg::ATAN_W'(i)));
         end else begin
            t = x + dx;
            y = y - dy;
            z += longint'(eyxz_pkg::atan_angle(eyxz_pkg::ATAN_W'(i)));
         end
         x = t;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function automatic logic [31:0] scaled_entry(longint e, longint m);
      longint r;
      r = (e * m + (64'sd1 << 29)) >>> 30;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic matrix_type transform_of(pose_type p);
      matrix_type r;
      longint s1, c1, s2, c2, s3, c3, s12, c1s2, sc, q;
      longint e [9];
      longint m [3];
      foreach (r.v[i]) r.v[i] = '0;
      if (p.kind == eyxz_pkg::KIND_NONE) return r;
      sine_cosine(p.rot[2], s3, c3);
      if (p.kind == eyxz_pkg::KIND_PLANAR) begin
         m[0] = longint'($signed(p.scale[0])) * 256;
         m[1] = longint'($signed(p.scale[1])) * 256;
         r.v[0] = scaled_entry(c3, m[0]);
         r.v[1] = scaled_entry(s3, m[0]);
         r.v[3] = scaled_entry(-s3, m[1]);
         r.v[4] = scaled_entry(c3, m[1]);
         return r;
      end
      sine_cosine(p.rot[0], s2, c2);
      sine_cosine(p.rot[1], s1, c1);
      s12 = round_q30(s1, s2);
      c1s2 = round_q30(c1, s2);
      e[0] = round_q30(c1, c3) + round_q30(s12, s3);
      e[1] = round_q30(c2, s3);
      e[2] = round_q30(c1s2, s3) - round_q30(c3, s1);
      e[3] = round_q30(s12, c3) - round_q30(c1, s3);
      e[4] = round_q30(c2, c3);
      e[5] = round_q30(c1s2, c3) + round_q30(s1, s3);
      e[6] = round_q30(c2, s1);
      e[7] = -s2;
      e[8] = round_q30(c1, c2);
      for (int j = 0; j < 3; j++) begin
         sc = $signed(p.scale[j]);
         if (p.kind == eyxz_pkg::KIND_MODEL) begin
            m[j] = sc * 256;
         end else if (sc == 0) begin
            m[j] = 64'sd2147483647;
         end else begin
            q = (64'sd1 << 24) / (sc < 0 ? -sc : sc);
            m[j] = sc < 0 ? -q : q;
         end
      end
      for (int j = 0; j < 9; j++) r.v[j] = scaled_entry(e[j], m[j / 3]);
      if (p.kind == eyxz_pkg::KIND_MODEL)
         for (int j = 0; j < 3; j++) r.v[9 + j] = p.pos[j];
      return r;
   endfunction

   class matrix_scoreboard;
      matrix_type pending [$];
      int errors = 0;
      int checked = 0;
      string names [12] = '{"col0_row0", "col0_row1", "col0_row2", "col1_row0",
                            "col1_row1", "col1_row2", "col2_row0", "col2_row1",
                            "col2_row2", "trans_x", "trans_y", "trans_z"};

      function void note_pose(pose_type p);
         pending.push_back(transform_of(p));
      endfunction

      function void check_matrix(matrix_type got);
         matrix_type want;
         if (pending.size() == 0) begin
            $error("result transfer with no item outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         foreach (got.v[i])
            if (got.v[i] !== want.v[i]) begin
               $error("%s: expected %h, got %h", names[i], want.v[i], got.v[i]);
               errors++;
            end
      endfunction
   endclass

   matrix_scoreboard board = new();

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      matrix_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_pose('{kind: req_kind, pos: '{req_pos_x, req_pos_y, req_pos_z},
                              rot: '{req_rot_x, req_rot_y, req_rot_z},
                              scale: '{req_scale_x, req_scale_y, req_scale_z}});
            kind_seen[req_kind]++;
         end
         if (rsp_valid && rsp_ready) begin
            got.v = '{rsp_col0_row0, rsp_col0_row1, rsp_col0_row2, rsp_col1_row0,
                      rsp_col1_row1, rsp_col1_row2, rsp_col2_row0, rsp_col2_row1,
                      rsp_col2_row2, rsp_trans_x, rsp_trans_y, rsp_trans_z};
            board.check_matrix(got);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_pose(pose_type p);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= p.kind;
      req_pos_x <= p.pos[0];
      req_pos_y <= p.pos[1];
      req_pos_z <= p.pos[2];
      req_rot_x <= p.rot[0];
      req_rot_y <= p.rot[1];
      req_rot_z <= p.rot[2];
      req_scale_x <= p.scale[0];
      req_scale_y <= p.scale[1];
      req_scale_z <= p.scale[2];
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         2: return 16'($signed(16'($urandom_range(2047))) - 16'sd1024);
         3: return $urandom_range(1) ? 16'h0001 : 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(4))
         0: return 16'(({$urandom_range(7)}) * 16'd8192 + $urandom_range(2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      p.kind = ($urandom_range(19) == 0) ? eyxz_pkg::KIND_NONE : 2'($urandom_range(2));
      foreach (p.pos[i]) p.pos[i] = $urandom;
      foreach (p.rot[i]) p.rot[i] = pick_angle();
      foreach (p.scale[i]) p.scale[i] = pick_scale();
      return p;
   endfunction

   task automatic run_directed();
      pose_type p;
      logic [15:0] angles [8] = '{16'h0000, 16'h4000, 16'h4001, 16'hC000, 16'hBFFF,
                                  16'h7FFF, 16'h8000, 16'h2000};
      logic [15:0] scales [6] = '{16'h0100, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
      for (int i = 0; i < 24; i++) begin
         p.kind = 2'(i % 4);
         p.pos = '{(i % 2) ? 32'h7FFFFFFF : 32'h80000000, 32'hFFFFFFFF, 32'h00010000};
         p.rot = '{angles[i % 8], angles[(i + 3) % 8], angles[(i + 5) % 8]};
         p.scale = '{scales[i % 6], scales[(i + 2) % 6], scales[(i + 4) % 6]};
         send_pose(p);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int i = 0; i < 1250; i++) begin
         if (i == 420) begin
            send_idle = 67;
            recv_idle = 14;
         end
         if (i == 840) begin
            send_idle = 0;
            recv_idle = 0;
         end
         send_pose(random_pose());
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      $display("Checked %0d matrices: %0d model, %0d normal, %0d planar, %0d unused kind.",
               board.checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("Idling was applied on each side in turn, then removed.");
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
